@@ rtl/psnrqm_pkg.sv @@
// Shared types and constants for the block PSNR quality map.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package psnrqm_pkg;

   localparam int BLOCK_SIZE_DEF     = 16;
   localparam int MAX_LINE_WIDTH_DEF = 4096;
   localparam int MAX_LINES          = 4096;
   localparam int LINE_W             = 12;
   localparam int DIM_W              = 14;
   localparam int CFG_W              = 13;
   localparam int LUMA_W             = 8;
   localparam int SQ_W               = 16;
   localparam int SUM_W              = 24;
   localparam int PC_W               = 9;
   localparam int IDX8_W             = 8;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [16:0]      PEAK_SQ = 17'd65025;
   localparam logic [13:0]      K_40DB  = 14'd10000;
   localparam logic [9:0]       K_30DB  = 10'd1000;
   localparam logic [6:0]       K_20DB  = 7'd100;

   localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   localparam logic [1:0] QC_EXCELLENT = 2'd0;
   localparam logic [1:0] QC_GOOD      = 2'd1;
   localparam logic [1:0] QC_FAIR      = 2'd2;
   localparam logic [1:0] QC_POOR      = 2'd3;

   localparam int RSP_FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W     = 3;
   localparam int FIFO_CNT_W     = 4;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   // Control flags of one pixel, decided from the position counters
   typedef struct packed {
      logic end_seg;
      logic first_line;
      logic emit;
   } seg_ctl_type;

   // Fixed-width fields that ride alongside a block sum
   typedef struct packed {
      logic              end_frame;
      logic [IDX8_W-1:0] block_row;
      logic [IDX8_W-1:0] block_col;
   } blk_meta_type;

   typedef struct packed {
      logic              frame_done;
      logic [1:0]        quality_class;
      logic [PC_W-1:0]   pixel_count;
      logic [SUM_W-1:0]  squared_error_sum;
      logic [IDX8_W-1:0] block_row;
      logic [IDX8_W-1:0] block_col;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/psnrqm_tracker.sv @@
// Pixel position tracker: column, line and in-block counters against the frame size.
// Depends on psnrqm_pkg.
`default_nettype none

module psnrqm_tracker #(
   parameter int BLOCK_SIZE     = psnrqm_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_LINE_WIDTH = psnrqm_pkg::MAX_LINE_WIDTH_DEF,
   localparam int BCOLS = (MAX_LINE_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
   localparam int BC_W  = (BCOLS > 1) ? $clog2(BCOLS) : 1,
   localparam int SUB_W = $clog2(BLOCK_SIZE),
   localparam int CNT_W = 2 * SUB_W + 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire logic [psnrqm_pkg::CFG_W-1:0]          frame_width,
   input  wire logic [psnrqm_pkg::CFG_W-1:0]          frame_height,
   output      psnrqm_pkg::seg_ctl_type               ctl,
   output      psnrqm_pkg::blk_meta_type              meta,
   output      logic [BC_W-1:0]                       bcol,
   output      logic [CNT_W-1:0]                      cnt
);
   import psnrqm_pkg::*;

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [SUB_W-1:0]  col_sub_ff, col_sub_in;
   logic [BC_W-1:0]   bcol_ff, bcol_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [SUB_W-1:0]  line_sub_ff, line_sub_in;
   logic [IDX8_W-1:0] brow_ff, brow_in;

   logic [DIM_W-1:0] w_clamp, h_clamp;
   logic end_line, last_line, end_frame, col_wrap, line_wrap;

   always_comb begin
      if (frame_width == '0) begin
         w_clamp = DIM_W'(1);
      end else if (DIM_W'(frame_width) > DIM_W'(MAX_LINE_WIDTH)) begin
         w_clamp = DIM_W'(MAX_LINE_WIDTH);
      end else begin
         w_clamp = DIM_W'(frame_width);
      end
      if (frame_height == '0) begin
         h_clamp = DIM_W'(1);
      end else if (DIM_W'(frame_height) > DIM_W'(MAX_LINES)) begin
         h_clamp = DIM_W'(MAX_LINES);
      end else begin
         h_clamp = DIM_W'(frame_height);
      end
   end

   assign col_wrap  = (col_sub_ff == SUB_W'(BLOCK_SIZE - 1));
   assign line_wrap = (line_sub_ff == SUB_W'(BLOCK_SIZE - 1));
   assign end_line  = DIM_W'(col_ff) >= (w_clamp - DIM_W'(1));
   assign last_line = DIM_W'(line_ff) >= (h_clamp - DIM_W'(1));
   assign end_frame = end_line && last_line;

   assign ctl.end_seg    = col_wrap || end_line;
   assign ctl.first_line = (line_sub_ff == '0);
   assign ctl.emit       = (col_wrap || end_line) && (line_wrap || last_line);

   assign meta.end_frame = end_frame;
   assign meta.block_row = brow_ff;
   assign meta.block_col = IDX8_W'(bcol_ff);
   assign bcol           = bcol_ff;
   assign cnt = CNT_W'((CNT_W'(col_sub_ff) + CNT_W'(1)) * (CNT_W'(line_sub_ff) + CNT_W'(1)));

   always_comb begin
      col_in      = col_ff;
      col_sub_in  = col_sub_ff;
      bcol_in     = bcol_ff;
      line_in     = line_ff;
      line_sub_in = line_sub_ff;
      brow_in     = brow_ff;
      if (advance) begin
         if (end_line) begin
            col_in     = '0;
            col_sub_in = '0;
            bcol_in    = '0;
            if (end_frame) begin
               line_in     = '0;
               line_sub_in = '0;
               brow_in     = '0;
            end else begin
               line_in     = line_ff + LINE_W'(1);
               line_sub_in = line_wrap ? '0 : line_sub_ff + SUB_W'(1);
               brow_in     = line_wrap ? brow_ff + IDX8_W'(1) : brow_ff;
            end
         end else begin
            col_in     = col_ff + COL_W'(1);
            col_sub_in = col_wrap ? '0 : col_sub_ff + SUB_W'(1);
            bcol_in    = col_wrap ? bcol_ff + BC_W'(1) : bcol_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         col_sub_ff  <= '0;
         bcol_ff     <= '0;
         line_ff     <= '0;
         line_sub_ff <= '0;
         brow_ff     <= '0;
      end else begin
         col_ff      <= col_in;
         col_sub_ff  <= col_sub_in;
         bcol_ff     <= bcol_in;
         line_ff     <= line_in;
         line_sub_ff <= line_sub_in;
         brow_ff     <= brow_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/psnrqm_accum.sv @@
// Squared-error accumulation: running segment sum and the per-block-column sum memory.
// Read-modify-write with a registered read and forwarding. Depends on psnrqm_pkg.
`default_nettype none

module psnrqm_accum #(
   parameter int BLOCK_SIZE     = psnrqm_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_LINE_WIDTH = psnrqm_pkg::MAX_LINE_WIDTH_DEF,
   localparam int BCOLS = (MAX_LINE_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
   localparam int BC_W  = (BCOLS > 1) ? $clog2(BCOLS) : 1,
   localparam int SUB_W = $clog2(BLOCK_SIZE),
   localparam int CNT_W = 2 * SUB_W + 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire logic [psnrqm_pkg::LUMA_W-1:0]         src_luma,
   input  wire logic [psnrqm_pkg::LUMA_W-1:0]         ref_luma,
   input  wire psnrqm_pkg::seg_ctl_type               in_ctl,
   input  wire psnrqm_pkg::blk_meta_type              in_meta,
   input  wire logic [BC_W-1:0]                       in_bcol,
   input  wire logic [CNT_W-1:0]                      in_cnt,
   output      logic                                  res_valid,
   output      logic [psnrqm_pkg::SUM_W-1:0]          res_sum,
   output      psnrqm_pkg::blk_meta_type              res_meta,
   output      logic [CNT_W-1:0]                      res_cnt
);
   import psnrqm_pkg::*;

   logic [SUM_W-1:0] sums_mem [BCOLS];

   logic [SUM_W-1:0] run_ff, run_in;
   logic [SUM_W-1:0] rd_data_ff;

   logic             s1_valid_ff;
   logic             s1_first_ff;
   logic             s1_emit_ff;
   logic [SUM_W-1:0] s1_seg_ff;
   logic [BC_W-1:0]  s1_addr_ff;
   blk_meta_type     s1_meta_ff;
   logic [CNT_W-1:0] s1_cnt_ff;

   logic             fwd_valid_ff;
   logic [BC_W-1:0]  fwd_addr_ff;
   logic [SUM_W-1:0] fwd_data_ff;

   logic [LUMA_W-1:0] diff;
   logic [SQ_W-1:0]   sq;
   logic [SUM_W:0]    seg_wide;
   logic [SUM_W-1:0]  seg_sum;
   logic [SUM_W-1:0]  base;
   logic [SUM_W:0]    tot_wide;
   logic [SUM_W-1:0]  total;
   logic              seg_close;

   assign diff     = (src_luma >= ref_luma) ? src_luma - ref_luma : ref_luma - src_luma;
   assign sq       = SQ_W'(diff) * SQ_W'(diff);
   assign seg_wide = {1'b0, run_ff} + (SUM_W + 1)'(sq);
   assign seg_sum  = seg_wide[SUM_W] ? SUM_MAX : seg_wide[SUM_W-1:0];
   assign seg_close = in_valid && in_ctl.end_seg;

   // Restart the segment once its sum has moved into stage one
   always_comb begin
      run_in = run_ff;
      if (in_valid) begin
         run_in = in_ctl.end_seg ? '0 : seg_sum;
      end
   end

   // The entry read last cycle missed a write that landed at the same edge
   assign base     = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : rd_data_ff;
   assign tot_wide = {1'b0, base} + {1'b0, s1_seg_ff};
   assign total    = s1_first_ff ? s1_seg_ff
                   : (tot_wide[SUM_W] ? SUM_MAX : tot_wide[SUM_W-1:0]);

   always_ff @(posedge clock) begin
      if (seg_close) begin
         rd_data_ff <= sums_mem[in_bcol];
      end
      if (s1_valid_ff) begin
         sums_mem[s1_addr_ff] <= total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         s1_valid_ff  <= seg_close;
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_close) begin
         s1_first_ff <= in_ctl.first_line;
         s1_emit_ff  <= in_ctl.emit;
         s1_seg_ff   <= seg_sum;
         s1_addr_ff  <= in_bcol;
         s1_meta_ff  <= in_meta;
         s1_cnt_ff   <= in_cnt;
      end
      if (s1_valid_ff) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= total;
      end
   end

   assign res_valid = s1_valid_ff && s1_emit_ff;
   assign res_sum   = total;
   assign res_meta  = s1_meta_ff;
   assign res_cnt   = s1_cnt_ff;

endmodule

`default_nettype wire

@@ rtl/psnrqm_classify.sv @@
// Quality class of a finished block: exact integer tests for the 40, 30 and 20 dB bands.
// Two registered stages, products then compares. Depends on psnrqm_pkg.
`default_nettype none

module psnrqm_classify #(
   parameter int BLOCK_SIZE = psnrqm_pkg::BLOCK_SIZE_DEF,
   localparam int SUB_W = $clog2(BLOCK_SIZE),
   localparam int CNT_W = 2 * SUB_W + 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire logic [psnrqm_pkg::SUM_W-1:0]          in_sum,
   input  wire psnrqm_pkg::blk_meta_type              in_meta,
   input  wire logic [CNT_W-1:0]                      in_cnt,
   output      logic                                  out_valid,
   output      psnrqm_pkg::rsp_type                   out_rsp
);
   import psnrqm_pkg::*;

   localparam int E4_W  = SUM_W + 14;
   localparam int E3_W  = SUM_W + 10;
   localparam int E2_W  = SUM_W + 7;
   localparam int LIM_W = 17 + CNT_W;
   localparam int CMP_W = (LIM_W > E4_W) ? LIM_W : E4_W;

   logic             c1_valid_ff;
   logic [E4_W-1:0]  c1_e4_ff;
   logic [E3_W-1:0]  c1_e3_ff;
   logic [E2_W-1:0]  c1_e2_ff;
   logic [LIM_W-1:0] c1_lim_ff;
   logic [SUM_W-1:0] c1_sum_ff;
   logic [PC_W-1:0]  c1_pc_ff;
   blk_meta_type     c1_meta_ff;

   logic             c2_valid_ff;
   rsp_type          c2_rsp_ff;

   logic [PC_W-1:0]  pc_sat;
   logic [1:0]       qclass;

   assign pc_sat = (32'(in_cnt) > 32'd511) ? PC_W'(511) : PC_W'(in_cnt);

   always_ff @(posedge clock) begin
      if (in_valid) begin
         c1_e4_ff   <= E4_W'(in_sum) * E4_W'(K_40DB);
         c1_e3_ff   <= E3_W'(in_sum) * E3_W'(K_30DB);
         c1_e2_ff   <= E2_W'(in_sum) * E2_W'(K_20DB);
         c1_lim_ff  <= LIM_W'(PEAK_SQ) * LIM_W'(in_cnt);
         c1_sum_ff  <= in_sum;
         c1_pc_ff   <= pc_sat;
         c1_meta_ff <= in_meta;
      end
   end

   always_comb begin
      if (CMP_W'(c1_e4_ff) <= CMP_W'(c1_lim_ff)) begin
         qclass = QC_EXCELLENT;
      end else if (CMP_W'(c1_e3_ff) <= CMP_W'(c1_lim_ff)) begin
         qclass = QC_GOOD;
      end else if (CMP_W'(c1_e2_ff) <= CMP_W'(c1_lim_ff)) begin
         qclass = QC_FAIR;
      end else begin
         qclass = QC_POOR;
      end
   end

   always_ff @(posedge clock) begin
      if (c1_valid_ff) begin
         c2_rsp_ff.frame_done        <= c1_meta_ff.end_frame;
         c2_rsp_ff.quality_class     <= qclass;
         c2_rsp_ff.pixel_count       <= c1_pc_ff;
         c2_rsp_ff.squared_error_sum <= c1_sum_ff;
         c2_rsp_ff.block_row         <= c1_meta_ff.block_row;
         c2_rsp_ff.block_col         <= c1_meta_ff.block_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= in_valid;
         c2_valid_ff <= c1_valid_ff;
      end
   end

   assign out_valid = c2_valid_ff;
   assign out_rsp   = c2_rsp_ff;

endmodule

`default_nettype wire

@@ rtl/block_psnr_quality_map_core.sv @@
// Block PSNR quality map, 16x16 blocks by default: one luma pair per cycle while results drain.
// A block result is offered from the result queue after the accumulator and both classify stages;
// the result queue holds 8 and req_tready drops while 8 results are queued or in flight.
// Sum memory: one synchronous port pair, one entry per block column, read-modify-write per segment.
// Reset clears position counters, running sum, pipeline and queue; the sum memory is not cleared,
// as the first line of each block row writes each entry without using its old value.
`default_nettype none

module block_psnr_quality_map_core #(
   parameter int BLOCK_SIZE     = psnrqm_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_LINE_WIDTH = psnrqm_pkg::MAX_LINE_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // tdata: src_luma[7:0], ref_luma[15:8]
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [psnrqm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tdata: block_col[7:0], block_row[15:8], squared_error_sum[39:16],
   //        pixel_count[48:40], quality_class[50:49], zeros above
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output      logic [psnrqm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                                  rsp_tlast,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [psnrqm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [psnrqm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import psnrqm_pkg::*;

   localparam int BCOLS = (MAX_LINE_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int BC_W  = (BCOLS > 1) ? $clog2(BCOLS) : 1;
   localparam int SUB_W = $clog2(BLOCK_SIZE);
   localparam int CNT_W = 2 * SUB_W + 2;

   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;

   logic             accept;
   seg_ctl_type      ctl;
   blk_meta_type     meta;
   logic [BC_W-1:0]  bcol;
   logic [CNT_W-1:0] cnt;

   logic             acc_valid;
   logic [SUM_W-1:0] acc_sum;
   blk_meta_type     acc_meta;
   logic [CNT_W-1:0] acc_cnt;

   logic             cls_valid;
   rsp_type          cls_rsp;

   rsp_type                 rsp_fifo [RSP_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   fifo_cnt_ff, fifo_cnt_in;
   logic [FIFO_CNT_W-1:0]   reserved_ff, reserved_in;
   logic                    push, pop, reserve;
   rsp_type                 head;

   // Configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= CFG_W'(csr_wdata);
            REG_FRAME_HEIGHT: frame_height_ff <= CFG_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Input side: admit an item only while a queue slot is free for any result
   assign req_tready = (reserved_ff < FIFO_CNT_W'(RSP_FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   psnrqm_tracker #(
      .BLOCK_SIZE     (BLOCK_SIZE),
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .ctl          (ctl),
      .meta         (meta),
      .bcol         (bcol),
      .cnt          (cnt)
   );

   psnrqm_accum #(
      .BLOCK_SIZE     (BLOCK_SIZE),
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .src_luma  (req_tdata[7:0]),
      .ref_luma  (req_tdata[15:8]),
      .in_ctl    (ctl),
      .in_meta   (meta),
      .in_bcol   (bcol),
      .in_cnt    (cnt),
      .res_valid (acc_valid),
      .res_sum   (acc_sum),
      .res_meta  (acc_meta),
      .res_cnt   (acc_cnt)
   );

   psnrqm_classify #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_sum    (acc_sum),
      .in_meta   (acc_meta),
      .in_cnt    (acc_cnt),
      .out_valid (cls_valid),
      .out_rsp   (cls_rsp)
   );

   // Result queue
   assign push    = cls_valid;
   assign pop     = rsp_tvalid && rsp_tready;
   assign reserve = accept && ctl.emit;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (push && !pop) begin
         fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         fifo_cnt_in = fifo_cnt_ff - FIFO_CNT_W'(1);
      end
      reserved_in = reserved_ff;
      if (reserve && !pop) begin
         reserved_in = reserved_ff + FIFO_CNT_W'(1);
      end else if (pop && !reserve) begin
         reserved_in = reserved_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_fifo[wr_ptr_ff] <= cls_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         reserved_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
         reserved_ff <= reserved_in;
      end
   end

   assign head       = rsp_fifo[rd_ptr_ff];
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tlast  = head.frame_done;
   assign rsp_tdata  = {5'b0, head.quality_class, head.pixel_count, head.squared_error_sum,
                        head.block_row, head.block_col};

   // Checks
   a_reserved_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= FIFO_CNT_W'(RSP_FIFO_DEPTH))
      else $error("result reservations exceed queue depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff < FIFO_CNT_W'(RSP_FIFO_DEPTH)) || pop)
      else $error("result pushed into a full queue");

   a_queue_reserved: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= reserved_ff)
      else $error("queued results not covered by reservations");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> head.pixel_count != '0)
      else $error("result with zero pixel count");

endmodule

`default_nettype wire
